@@ rtl/core/e2cd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package e2cd_pkg;

    localparam logic [31:0] EPOCH_2000   = 32'd946684800;
    localparam logic [8:0]  YEAR_DAYS    = 9'd365;
    localparam logic [6:0]  CENTURY_YOFF = 7'd100;
    localparam logic [5:0]  DIV_60       = 6'd60;
    localparam logic [5:0]  DIV_24       = 6'd24;
    localparam logic [2:0]  WD_START     = 3'd6;
    localparam logic [3:0]  WEEK_DAYS    = 4'd7;
    localparam logic [4:0]  SHORT_MONTH  = 5'd28;
    localparam logic [3:0]  FEB          = 4'd1;
    localparam logic [3:0]  LAST_MONTH   = 4'd11;

    // x / 60 = (x * RECIP_60) >> 37, x / 24 = (x * RECIP_24) >> 36, exact for 32-bit x
    localparam logic [31:0] RECIP_60     = 32'h8888_8889;
    localparam logic [31:0] RECIP_24     = 32'hAAAA_AAAB;

    localparam logic        DIV_LAST     = 1'b1;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [2:0] DAY_MOD7 [32] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd0, 3'd1, 3'd2, 3'd3
    };

    typedef enum logic [1:0] {
        CAP_SEC,
        CAP_MIN,
        CAP_HOUR
    } cap_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_last;
        cap_t cap;
        logic year_step;
        logic month_step;
        logic out_load;
    } e2cd_cmd_t;

    typedef struct packed {
        logic oor;
        logic year_fit;
        logic month_end;
        logic out_free;
    } e2cd_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/e2cd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module e2cd_ctrl
    import e2cd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       epoch_valid,
    output logic            epoch_stall,
    input  wire e2cd_stat_t stat,
    output e2cd_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_YEAR  = 5'b00100,
        ST_MONTH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic       cnt_reg, cnt_next;
    cap_t       cap_reg, cap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 1'b0;
            cap_reg   <= CAP_SEC;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cap_reg   <= cap_next;
        end
    end

    assign epoch_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cap_next   = cap_reg;
        cmd        = '0;
        cmd.cap    = cap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (epoch_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = 1'b0;
                    cap_next   = CAP_SEC;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.oor)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cmd.div_last = (cnt_reg == DIV_LAST);
                    cnt_next     = cnt_reg + 1'b1;
                    if (cmd.div_last)
                    begin
                        unique case (cap_reg)
                            CAP_SEC:  cap_next = CAP_MIN;
                            CAP_MIN:  cap_next = CAP_HOUR;
                            default:  state_next = ST_YEAR;
                        endcase
                    end
                end
            end
            ST_YEAR:
            begin
                cmd.year_step = 1'b1;
                if (stat.year_fit)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                cmd.month_step = 1'b1;
                if (stat.month_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/e2cd_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module e2cd_dpath
    import e2cd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire e2cd_cmd_t   cmd,
    output e2cd_stat_t       stat,
    input  wire logic [31:0] epoch_seconds,
    output logic             date_valid,
    input  wire logic        date_stall,
    output logic [6:0]       year_offset,
    output logic [3:0]       month_number,
    output logic [4:0]       day_of_month,
    output logic [4:0]       hour_of_day,
    output logic [5:0]       minute_of_hour,
    output logic [5:0]       second_of_minute,
    output logic [2:0]       weekday,
    output logic             out_of_range
);

    logic [31:0] q_reg, q_next;
    logic [31:0] quo_reg, quo_next;
    logic        oor_reg, oor_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [6:0]  yoff_reg, yoff_next;
    logic [3:0]  mon_reg, mon_next;
    logic [2:0]  wd_reg, wd_next;

    logic [6:0]  o_year_reg, o_year_next;
    logic [3:0]  o_mon_reg, o_mon_next;
    logic [4:0]  o_day_reg, o_day_next;
    logic [4:0]  o_hour_reg, o_hour_next;
    logic [5:0]  o_min_reg, o_min_next;
    logic [5:0]  o_sec_reg, o_sec_next;
    logic [2:0]  o_wd_reg, o_wd_next;
    logic        o_oor_reg, o_oor_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] div_q;
    logic [5:0]  div_r;
    logic [5:0]  divisor;
    logic [31:0] recip;
    logic [63:0] prod;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [15:0] days;

    function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= WEEK_DAYS)
        begin
            s = s - WEEK_DAYS;
        end
        return s[2:0];
    endfunction

    // reciprocal multiply: quotient on the first division step, remainder on the last
    always_comb
    begin
        divisor = (cmd.cap == CAP_HOUR) ? DIV_24 : DIV_60;
        recip   = (cmd.cap == CAP_HOUR) ? RECIP_24 : RECIP_60;
        prod    = {32'd0, q_reg} * {32'd0, recip};
        div_q   = (cmd.cap == CAP_HOUR) ? {4'd0, prod[63:36]} : {5'd0, prod[63:37]};
        div_r   = q_reg[5:0] - 6'(quo_reg[5:0] * divisor);
    end

    assign days = q_reg[15:0];
    assign leap = (yoff_reg[1:0] == 2'b00) && (yoff_reg != CENTURY_YOFF);
    assign ylen = YEAR_DAYS + {8'd0, leap};
    assign mlen = MONTH_LEN[mon_reg] + {4'd0, leap && (mon_reg == FEB)};

    assign stat.oor       = oor_reg;
    assign stat.year_fit  = (days < {7'd0, ylen});
    assign stat.month_end = (days < {11'd0, mlen}) || (mon_reg == LAST_MONTH);
    assign stat.out_free  = !out_valid_reg || !date_stall;

    always_comb
    begin
        q_next    = q_reg;
        quo_next  = quo_reg;
        oor_next  = oor_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        yoff_next = yoff_reg;
        mon_next  = mon_reg;
        wd_next   = wd_reg;

        o_year_next = o_year_reg;
        o_mon_next  = o_mon_reg;
        o_day_next  = o_day_reg;
        o_hour_next = o_hour_reg;
        o_min_next  = o_min_reg;
        o_sec_next  = o_sec_reg;
        o_wd_next   = o_wd_reg;
        o_oor_next  = o_oor_reg;

        if (cmd.load)
        begin
            q_next    = epoch_seconds - EPOCH_2000;
            oor_next  = (epoch_seconds < EPOCH_2000);
            yoff_next = '0;
            mon_next  = '0;
            wd_next   = WD_START;
        end

        if (cmd.div_step)
        begin
            if (cmd.div_last)
            begin
                q_next = quo_reg;
                unique case (cmd.cap)
                    CAP_SEC:  sec_next  = div_r;
                    CAP_MIN:  min_next  = div_r;
                    default:  hour_next = div_r[4:0];
                endcase
            end
            else
            begin
                quo_next = div_q;
            end
        end

        if (cmd.year_step && !stat.year_fit)
        begin
            q_next    = {16'd0, days - {7'd0, ylen}};
            yoff_next = yoff_reg + 7'd1;
            wd_next   = wd_add(wd_reg, leap ? 3'd2 : 3'd1);
        end

        if (cmd.month_step && !stat.month_end)
        begin
            q_next   = {16'd0, days - {11'd0, mlen}};
            mon_next = mon_reg + 4'd1;
            wd_next  = wd_add(wd_reg, 3'(mlen - SHORT_MONTH));
        end

        if (cmd.out_load)
        begin
            o_oor_next = oor_reg;
            if (oor_reg)
            begin
                o_year_next = '0;
                o_mon_next  = '0;
                o_day_next  = '0;
                o_hour_next = '0;
                o_min_next  = '0;
                o_sec_next  = '0;
                o_wd_next   = '0;
            end
            else
            begin
                o_year_next = yoff_reg;
                o_mon_next  = mon_reg + 4'd1;
                o_day_next  = days[4:0] + 5'd1;
                o_hour_next = hour_reg;
                o_min_next  = min_reg;
                o_sec_next  = sec_reg;
                o_wd_next   = wd_add(wd_reg, DAY_MOD7[days[4:0]]);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (date_valid && !date_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        quo_reg     <= quo_next;
        oor_reg     <= oor_next;
        sec_reg     <= sec_next;
        min_reg     <= min_next;
        hour_reg    <= hour_next;
        yoff_reg    <= yoff_next;
        mon_reg     <= mon_next;
        wd_reg      <= wd_next;
        o_year_reg  <= o_year_next;
        o_mon_reg   <= o_mon_next;
        o_day_reg   <= o_day_next;
        o_hour_reg  <= o_hour_next;
        o_min_reg   <= o_min_next;
        o_sec_reg   <= o_sec_next;
        o_wd_reg    <= o_wd_next;
        o_oor_reg   <= o_oor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign date_valid       = out_valid_reg;
    assign year_offset      = o_year_reg;
    assign month_number     = o_mon_reg;
    assign day_of_month     = o_day_reg;
    assign hour_of_day      = o_hour_reg;
    assign minute_of_hour   = o_min_reg;
    assign second_of_minute = o_sec_reg;
    assign weekday          = o_wd_reg;
    assign out_of_range     = o_oor_reg;

endmodule

`default_nettype wire

@@ rtl/core/epoch_to_calendar_date_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// epoch     epoch_valid / epoch_stall  epoch_seconds
// date      date_valid / date_stall    year_offset .. weekday, out_of_range
//
// One transfer in at a time. Three divisions (by 60, 60, 24), each a reciprocal
// multiply then a remainder, are followed by whole years taken off one at a time,
// then whole months one at a time, then one output load; the next transfer in is
// taken only after that load. Out-of-range timestamps skip the divisions, years
// and months and go from the divide state straight to the output load.
// rst_n clears the controller and the output valid only. A stalled result holds
// the next one in the done state, and epoch_stall stays high until it is loaded.

module epoch_to_calendar_date_top
    import e2cd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        epoch_valid,
    output logic             epoch_stall,
    input  wire logic [31:0] epoch_seconds,
    output logic             date_valid,
    input  wire logic        date_stall,
    output logic [6:0]       year_offset,
    output logic [3:0]       month_number,
    output logic [4:0]       day_of_month,
    output logic [4:0]       hour_of_day,
    output logic [5:0]       minute_of_hour,
    output logic [5:0]       second_of_minute,
    output logic [2:0]       weekday,
    output logic             out_of_range
);

    e2cd_cmd_t  cmd;
    e2cd_stat_t stat;

    e2cd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .epoch_valid (epoch_valid),
        .epoch_stall (epoch_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    e2cd_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .epoch_seconds    (epoch_seconds),
        .date_valid       (date_valid),
        .date_stall       (date_stall),
        .year_offset      (year_offset),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .weekday          (weekday),
        .out_of_range     (out_of_range)
    );

endmodule

`default_nettype wire

@@ test/epoch_to_calendar_date_top_tb.sv @@
`timescale 1ns / 1ps

module epoch_to_calendar_date_top_tb;
    import e2cd_pkg::*;

    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [6:0] year_offset;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
        logic [2:0] weekday;
        logic       out_of_range;
    } calendar_date_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        epoch_valid = 1'b0;
    logic        epoch_stall;
    logic [31:0] epoch_seconds = '0;
    logic        date_valid;
    logic        date_stall = 1'b0;
    logic [6:0]  year_offset;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [2:0]  weekday;
    logic        out_of_range;

    calendar_date_t pending_dates [$];
    int unsigned    mismatch_count = 0;
    bit             sender_idle = 1'b0;
    bit             stall_idle = 1'b0;

    epoch_to_calendar_date_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .epoch_valid      (epoch_valid),
        .epoch_stall      (epoch_stall),
        .epoch_seconds    (epoch_seconds),
        .date_valid       (date_valid),
        .date_stall       (date_stall),
        .year_offset      (year_offset),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .weekday          (weekday),
        .out_of_range     (out_of_range)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned days_in_year(input int unsigned year);
        if (year % 4 == 0 && (year % 100 != 0 || year % 400 == 0))
            return 366;
        return 365;
    endfunction

    // month index from 0
    function automatic int unsigned days_in_month(input int unsigned year,
                                                  input int unsigned mon);
        if (mon == 1 && days_in_year(year) == 366)
            return 29;
        return MONTH_DAYS[mon];
    endfunction

    function automatic logic [31:0] epoch_of_date(input int unsigned year, input int unsigned month,
                                                  input int unsigned day, input int unsigned hh,
                                                  input int unsigned mm, input int unsigned ss);
        longint unsigned days;
        days = 0;
        for (int unsigned y = 2000; y < year; y++)
            days += days_in_year(y);
        for (int unsigned m = 0; m + 1 < month; m++)
            days += days_in_month(year, m);
        days += day - 1;
        return 32'(longint'(EPOCH_2000) + days * SECS_PER_DAY + hh * 3600 + mm * 60 + ss);
    endfunction

    function automatic calendar_date_t calendar_from_epoch(input logic [31:0] ts);
        calendar_date_t  d;
        int unsigned     rest;
        int unsigned     day_count;
        int unsigned     days_left;
        int unsigned     yoff;
        int unsigned     mon;
        d = '0;
        if (ts < EPOCH_2000)
        begin
            d.out_of_range = 1'b1;
            return d;
        end
        rest = ts - EPOCH_2000;
        d.second_of_minute = 6'(rest % 60);
        rest = rest / 60;
        d.minute_of_hour = 6'(rest % 60);
        rest = rest / 60;
        d.hour_of_day = 5'(rest % 24);
        day_count = rest / 24;
        days_left = day_count;
        yoff = 0;
        while (days_left >= days_in_year(2000 + yoff))
        begin
            days_left -= days_in_year(2000 + yoff);
            yoff++;
        end
        mon = 0;
        while (mon < 11 && days_left >= days_in_month(2000 + yoff, mon))
        begin
            days_left -= days_in_month(2000 + yoff, mon);
            mon++;
        end
        d.year_offset = 7'(yoff);
        d.month_number = 4'(mon + 1);
        d.day_of_month = 5'(days_left + 1);
        d.weekday = 3'((day_count + 6) % 7);
        return d;
    endfunction

    function automatic logic [31:0] random_date_epoch();
        int unsigned year;
        int unsigned month;
        int unsigned last_day;
        int unsigned day;
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        year = $urandom_range(0, 3) == 0 ? $urandom_range(2096, 2105) : $urandom_range(2000, 2105);
        month = $urandom_range(1, 12);
        last_day = days_in_month(year, month - 1);
        case ($urandom_range(0, 3))
            0: day = 1;
            1: day = last_day;
            2: day = last_day - 1;
            default: day = $urandom_range(1, last_day);
        endcase
        hh = $urandom_range(0, 1) ? $urandom_range(0, 23) : ($urandom_range(0, 1) ? 23 : 0);
        mm = $urandom_range(0, 1) ? $urandom_range(0, 59) : ($urandom_range(0, 1) ? 59 : 0);
        ss = $urandom_range(0, 1) ? $urandom_range(0, 59) : ($urandom_range(0, 1) ? 59 : 0);
        return epoch_of_date(year, month, day, hh, mm, ss);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned exp);
        mismatch_count++;
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, exp);
    endtask

    task automatic send_epoch(input logic [31:0] ts);
        int unsigned gap;
        gap = (sender_idle && $urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
        if (gap != 0)
        begin
            epoch_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        epoch_valid   <= 1'b1;
        epoch_seconds <= ts;
        do
            @(posedge clk);
        while (epoch_stall);
        pending_dates.push_back(calendar_from_epoch(ts));
    endtask

    // receiver back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_idle && $urandom_range(0, 4) == 0)
            begin
                date_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                date_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        calendar_date_t exp;
        if (rst_n && date_valid && !date_stall)
        begin
            if (pending_dates.size() == 0)
                report_mismatch("transfer with nothing pending", 1, 0);
            else
            begin
                exp = pending_dates.pop_front();
                if (year_offset !== exp.year_offset)
                    report_mismatch("year_offset", year_offset, exp.year_offset);
                if (month_number !== exp.month_number)
                    report_mismatch("month_number", month_number, exp.month_number);
                if (day_of_month !== exp.day_of_month)
                    report_mismatch("day_of_month", day_of_month, exp.day_of_month);
                if (hour_of_day !== exp.hour_of_day)
                    report_mismatch("hour_of_day", hour_of_day, exp.hour_of_day);
                if (minute_of_hour !== exp.minute_of_hour)
                    report_mismatch("minute_of_hour", minute_of_hour, exp.minute_of_hour);
                if (second_of_minute !== exp.second_of_minute)
                    report_mismatch("second_of_minute", second_of_minute, exp.second_of_minute);
                if (weekday !== exp.weekday)
                    report_mismatch("weekday", weekday, exp.weekday);
                if (out_of_range !== exp.out_of_range)
                    report_mismatch("out_of_range", out_of_range, exp.out_of_range);
            end
        end
    end

    task automatic test_range_limits();
        send_epoch(32'd0);
        send_epoch(32'd1);
        send_epoch(EPOCH_2000 - 32'd1);
        send_epoch(EPOCH_2000);
        send_epoch(EPOCH_2000 + 32'd86399);
        send_epoch(32'h7FFF_FFFF);
        send_epoch(32'h8000_0000);
        send_epoch(32'hAAAA_AAAA);
        send_epoch(32'h5555_5555);
        send_epoch(32'hFFFF_FFFE);
        send_epoch(32'hFFFF_FFFF);
    endtask

    task automatic test_leap_rules();
        send_epoch(epoch_of_date(2000, 2, 28, 23, 59, 59));
        send_epoch(epoch_of_date(2000, 2, 29, 0, 0, 0));
        send_epoch(epoch_of_date(2000, 12, 31, 23, 59, 59));
        send_epoch(epoch_of_date(2001, 1, 1, 0, 0, 0));
        send_epoch(epoch_of_date(2004, 2, 29, 12, 34, 56));
        send_epoch(epoch_of_date(2099, 12, 31, 23, 59, 59));
        send_epoch(epoch_of_date(2100, 2, 28, 23, 59, 59));
        send_epoch(epoch_of_date(2100, 3, 1, 0, 0, 0));
        send_epoch(epoch_of_date(2105, 12, 31, 23, 59, 59));
    endtask

    // sender holds off until the pipeline has fully drained
    task automatic test_drain_pause();
        send_epoch(random_date_epoch());
        send_epoch(random_date_epoch());
        epoch_valid <= 1'b0;
        wait (pending_dates.size() == 0);
        @(posedge clk);
        send_epoch(random_date_epoch());
        send_epoch(EPOCH_2000 - 32'd5);
    endtask

    task automatic test_random_dates(input int unsigned count, input bit allow_idle);
        logic [31:0] ts;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                sender_idle = allow_idle && $urandom_range(0, 3) != 0;
                stall_idle  = allow_idle && $urandom_range(0, 3) != 0;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: ts = $urandom();
                7:       ts = EPOCH_2000 - 32'd50000 + 32'($urandom_range(0, 100000));
                8:       ts = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000000));
                default: ts = random_date_epoch();
            endcase
            send_epoch(ts);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_idle = 1'b1;
        stall_idle  = 1'b1;
        test_range_limits();
        test_leap_rules();
        test_drain_pause();
        test_random_dates(680, 1'b1);
        sender_idle = 1'b0;
        stall_idle  = 1'b0;
        test_random_dates(100, 1'b0);
        epoch_valid <= 1'b0;
        wait (pending_dates.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
